### rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// shared types and constants for the 3x3 matrix inverse core
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int NUM_ELEM = 9;
    localparam int IDX_W    = 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEM - 1);

    // cofactor i = m[PA]*m[PB] - m[PC]*m[PD], elements in row-major order
    localparam int PA [NUM_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int PB [NUM_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int PC [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int PD [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic             last;
        logic             sing;
        logic [IDX_W-1:0] idx;
    } div_tag_t;

endpackage

### rtl/mi3_if.sv
// ----------------------------------------------------------------------------
// mi3 channel interfaces
// valid/ready channels for matrix beats and inverse beats
// ----------------------------------------------------------------------------
interface mi3_in_if #(parameter int ELEMENT_WIDTH = 32);
    logic                            valid;
    logic                            ready;
    logic signed [ELEMENT_WIDTH-1:0] m11;
    logic signed [ELEMENT_WIDTH-1:0] m12;
    logic signed [ELEMENT_WIDTH-1:0] m13;
    logic signed [ELEMENT_WIDTH-1:0] m21;
    logic signed [ELEMENT_WIDTH-1:0] m22;
    logic signed [ELEMENT_WIDTH-1:0] m23;
    logic signed [ELEMENT_WIDTH-1:0] m31;
    logic signed [ELEMENT_WIDTH-1:0] m32;
    logic signed [ELEMENT_WIDTH-1:0] m33;

    modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    input ready);
    modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    output ready);
endinterface

interface mi3_out_if #(parameter int ELEMENT_WIDTH = 32);
    logic                            valid;
    logic                            ready;
    logic signed [ELEMENT_WIDTH-1:0] r11;
    logic signed [ELEMENT_WIDTH-1:0] r12;
    logic signed [ELEMENT_WIDTH-1:0] r13;
    logic signed [ELEMENT_WIDTH-1:0] r21;
    logic signed [ELEMENT_WIDTH-1:0] r22;
    logic signed [ELEMENT_WIDTH-1:0] r23;
    logic signed [ELEMENT_WIDTH-1:0] r31;
    logic signed [ELEMENT_WIDTH-1:0] r32;
    logic signed [ELEMENT_WIDTH-1:0] r33;
    logic                            singular;

    modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33, singular,
                    input ready);
    modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33, singular,
                    output ready);
endinterface

### rtl/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front
// five-stage pipeline: 2x2 products, cofactors, split products, det terms, det
// ----------------------------------------------------------------------------
module mi3_front #(
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [ELEMENT_WIDTH-1:0]   m_in [mi3_pkg::NUM_ELEM],
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [3*ELEMENT_WIDTH+2:0] det,
    output logic signed [2*ELEMENT_WIDTH:0]   cof [mi3_pkg::NUM_ELEM],
    output logic signed [ELEMENT_WIDTH-1:0]   m_out [mi3_pkg::NUM_ELEM]
);
    import mi3_pkg::*;

    localparam int E    = ELEMENT_WIDTH;
    localparam int P_W  = 2 * E;
    localparam int PL_W = 2 * E + 2;
    localparam int C_W  = 2 * E + 1;
    localparam int D_W  = 3 * E + 3;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                  fen;
    logic signed [P_W-1:0] pp1_reg [NUM_ELEM];
    logic signed [P_W-1:0] pq1_reg [NUM_ELEM];
    logic signed [E-1:0]   m1_reg  [NUM_ELEM];
    logic signed [E-1:0]   m2_reg  [NUM_ELEM];
    logic signed [E-1:0]   m3_reg  [NUM_ELEM];
    logic signed [E-1:0]   m4_reg  [NUM_ELEM];
    logic signed [E-1:0]   m5_reg  [NUM_ELEM];
    logic signed [C_W-1:0] c2_reg  [NUM_ELEM];
    logic signed [C_W-1:0] c3_reg  [NUM_ELEM];
    logic signed [C_W-1:0] c4_reg  [NUM_ELEM];
    logic signed [C_W-1:0] c5_reg  [NUM_ELEM];
    logic signed [P_W-1:0] ph3_reg [3];
    logic signed [PL_W-1:0] pl3_reg [3];
    logic signed [D_W-1:0] t4_reg  [3];
    logic signed [D_W-1:0] det5_reg;

    assign fen      = !v5_reg || out_ready;
    assign in_ready = fen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (fen)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            for (int i = 0; i < NUM_ELEM; i++)
            begin
                pp1_reg[i] <= P_W'(m_in[PA[i]]) * P_W'(m_in[PB[i]]);
                pq1_reg[i] <= P_W'(m_in[PC[i]]) * P_W'(m_in[PD[i]]);
                m1_reg[i]  <= m_in[i];
                c2_reg[i]  <= C_W'(pp1_reg[i]) - C_W'(pq1_reg[i]);
                m2_reg[i]  <= m1_reg[i];
                c3_reg[i]  <= c2_reg[i];
                m3_reg[i]  <= m2_reg[i];
                c4_reg[i]  <= c3_reg[i];
                m4_reg[i]  <= m3_reg[i];
                c5_reg[i]  <= c4_reg[i];
                m5_reg[i]  <= m4_reg[i];
            end
            // det = m11*c11 + m21*c12 + m31*c13, cofactor split into high and low parts
            for (int k = 0; k < 3; k++)
            begin
                ph3_reg[k] <= P_W'(m2_reg[3*k]) * P_W'($signed(c2_reg[k][C_W-1:E+1]));
                pl3_reg[k] <= PL_W'(m2_reg[3*k]) * PL_W'($signed({1'b0, c2_reg[k][E:0]}));
                t4_reg[k]  <= (D_W'(ph3_reg[k]) <<< (E + 1)) + D_W'(pl3_reg[k]);
            end
            det5_reg <= t4_reg[0] + t4_reg[1] + t4_reg[2];
        end
    end

    assign out_valid = v5_reg;
    assign det       = det5_reg;
    assign cof       = c5_reg;
    assign m_out     = m5_reg;

endmodule

### rtl/mi3_serial.sv
// ----------------------------------------------------------------------------
// mi3_serial
// holds one matrix and issues its nine cofactor divisions one per cycle while en is high
// ----------------------------------------------------------------------------
module mi3_serial #(
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [3*ELEMENT_WIDTH+2:0] det,
    input  logic signed [2*ELEMENT_WIDTH:0]   cof [mi3_pkg::NUM_ELEM],
    input  logic signed [ELEMENT_WIDTH-1:0]   m_in [mi3_pkg::NUM_ELEM],
    input  logic                              en,
    output logic                              req_valid,
    output mi3_pkg::div_tag_t                 req_tag,
    output logic signed [2*ELEMENT_WIDTH:0]   req_cof,
    output logic signed [3*ELEMENT_WIDTH+2:0] req_det,
    output logic signed [ELEMENT_WIDTH-1:0]   req_pass
);
    import mi3_pkg::*;

    localparam int E   = ELEMENT_WIDTH;
    localparam int C_W = 2 * E + 1;
    localparam int D_W = 3 * E + 3;

    logic                  busy_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic                  sing_reg;
    logic signed [D_W-1:0] det_reg;
    logic signed [C_W-1:0] cof_reg [NUM_ELEM];
    logic signed [E-1:0]   m_reg   [NUM_ELEM];
    logic                  issue;
    logic                  last;

    assign issue    = busy_reg && en;
    assign last     = (cnt_reg == LAST_IDX);
    assign in_ready = !busy_reg || (issue && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (in_valid && in_ready)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (issue && last)
        begin
            busy_reg <= 1'b0;
        end
        else if (issue)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            det_reg  <= det;
            sing_reg <= (det == '0);
            cof_reg  <= cof;
            m_reg    <= m_in;
        end
    end

    assign req_valid    = busy_reg;
    assign req_tag.last = last;
    assign req_tag.sing = sing_reg;
    assign req_tag.idx  = cnt_reg;
    assign req_cof      = cof_reg[cnt_reg];
    assign req_det      = det_reg;
    assign req_pass     = m_reg[cnt_reg];

endmodule

### rtl/mi3_div.sv
// ----------------------------------------------------------------------------
// mi3_div
// pipelined restoring divider, saturating; one quotient bit per later stage
// ----------------------------------------------------------------------------
module mi3_div #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRAC_BITS     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  mi3_pkg::div_tag_t                 in_tag,
    input  logic signed [2*ELEMENT_WIDTH:0]   in_cof,
    input  logic signed [3*ELEMENT_WIDTH+2:0] in_det,
    input  logic signed [ELEMENT_WIDTH-1:0]   in_pass,
    output logic                              out_valid,
    output mi3_pkg::div_tag_t                 out_tag,
    output logic signed [ELEMENT_WIDTH-1:0]   out_value
);
    import mi3_pkg::*;

    localparam int E   = ELEMENT_WIDTH;
    localparam int C_W = 2 * E + 1;
    localparam int D_W = 3 * E + 3;
    localparam int N_W = C_W + 2 * FRAC_BITS;
    localparam int DS_W = D_W + E - 1;
    localparam int RW  = (N_W > DS_W) ? N_W : DS_W;
    localparam logic [E-1:0] MAXV = {1'b0, {(E-1){1'b1}}};
    localparam logic [E-1:0] MINV = {1'b1, {(E-1){1'b0}}};

    logic                v_reg    [E+1];
    logic [RW-1:0]       r_reg    [E+1];
    logic [D_W-1:0]      d_reg    [E+1];
    logic [E-2:0]        q_reg    [E+1];
    logic                neg_reg  [E+1];
    logic                sat_reg  [E+1];
    div_tag_t            tag_reg  [E+1];
    logic signed [E-1:0] pass_reg [E+1];

    logic [C_W-1:0]      cmag;
    logic [D_W-1:0]      dmag;
    logic                ov_reg;
    div_tag_t            otag_reg;
    logic signed [E-1:0] oval_reg;
    logic [E-1:0]        qe;
    logic [E-1:0]        res;

    assign cmag = in_cof[C_W-1] ? C_W'(-in_cof) : C_W'(in_cof);
    assign dmag = in_det[D_W-1] ? D_W'(-in_det) : D_W'(in_det);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= RW'(cmag) << (2 * FRAC_BITS);
            d_reg[0]    <= dmag;
            q_reg[0]    <= '0;
            neg_reg[0]  <= in_cof[C_W-1] ^ in_det[D_W-1];
            sat_reg[0]  <= 1'b0;
            tag_reg[0]  <= in_tag;
            pass_reg[0] <= in_pass;
        end
    end

    for (genvar k = 0; k < E; k++)
    begin : g_step
        localparam int S = E - 1 - k;
        logic [RW-1:0] dsh;
        logic          ge;

        assign dsh = RW'(d_reg[k]) << S;
        assign ge  = (r_reg[k] >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        if (k == 0)
        begin : g_sat
            // quotient reaches 2^(E-1): saturate
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k+1]   <= r_reg[k];
                    q_reg[k+1]   <= q_reg[k];
                    sat_reg[k+1] <= ge;
                end
            end
        end
        else
        begin : g_bit
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k+1]   <= ge ? (r_reg[k] - dsh) : r_reg[k];
                    q_reg[k+1]   <= q_reg[k] | ((E-1)'(ge) << S);
                    sat_reg[k+1] <= sat_reg[k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k+1]    <= d_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                tag_reg[k+1]  <= tag_reg[k];
                pass_reg[k+1] <= pass_reg[k];
            end
        end
    end

    assign qe = {1'b0, q_reg[E]};

    always_comb
    begin
        if (tag_reg[E].sing)
            res = pass_reg[E];
        else if (sat_reg[E])
            res = neg_reg[E] ? MINV : MAXV;
        else
            res = neg_reg[E] ? (E'(0) - qe) : qe;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= v_reg[E];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            otag_reg <= tag_reg[E];
            oval_reg <= res;
        end
    end

    assign out_valid = ov_reg;
    assign out_tag   = otag_reg;
    assign out_value = oval_reg;

endmodule

### rtl/matrix3x3_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// 3x3 fixed-point matrix inverse by adjugate with saturating division
//
//   channel   dir   beat                          handshake
//   in_ch     in    m11..m33                      valid/ready
//   out_ch    out   r11..r33, singular            valid/ready
//
// the single divider pipeline is shared by the nine cofactors, so a matrix's
// divisions issue one after another; the serializer takes the next matrix as the last one issues
// reset clears valid state only; no clearing pass
// out_ch stall freezes the divider pipeline; until its last stage holds a waiting
// matrix, the front pipeline keeps taking a new matrix while one is in division
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRAC_BITS     = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    mi3_in_if.sink    in_ch,
    mi3_out_if.source out_ch
);
    import mi3_pkg::*;

    localparam int E   = ELEMENT_WIDTH;
    localparam int C_W = 2 * E + 1;
    localparam int D_W = 3 * E + 3;

    logic signed [E-1:0]   m_in  [NUM_ELEM];
    logic                  f_valid;
    logic                  f_ready;
    logic signed [D_W-1:0] f_det;
    logic signed [C_W-1:0] f_cof [NUM_ELEM];
    logic signed [E-1:0]   f_m   [NUM_ELEM];

    logic                  div_en;
    logic                  req_valid;
    div_tag_t              req_tag;
    logic signed [C_W-1:0] req_cof;
    logic signed [D_W-1:0] req_det;
    logic signed [E-1:0]   req_pass;

    logic                  dv_valid;
    div_tag_t              dv_tag;
    logic signed [E-1:0]   dv_value;

    logic signed [E-1:0]   asm_reg [NUM_ELEM];
    logic signed [E-1:0]   r_reg   [NUM_ELEM];
    logic                  sing_reg;
    logic                  ov_reg;

    assign m_in[0] = in_ch.m11;
    assign m_in[1] = in_ch.m12;
    assign m_in[2] = in_ch.m13;
    assign m_in[3] = in_ch.m21;
    assign m_in[4] = in_ch.m22;
    assign m_in[5] = in_ch.m23;
    assign m_in[6] = in_ch.m31;
    assign m_in[7] = in_ch.m32;
    assign m_in[8] = in_ch.m33;

    mi3_front #(.ELEMENT_WIDTH(E)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .m_in      (m_in),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .det       (f_det),
        .cof       (f_cof),
        .m_out     (f_m)
    );

    mi3_serial #(.ELEMENT_WIDTH(E)) u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .det       (f_det),
        .cof       (f_cof),
        .m_in      (f_m),
        .en        (div_en),
        .req_valid (req_valid),
        .req_tag   (req_tag),
        .req_cof   (req_cof),
        .req_det   (req_det),
        .req_pass  (req_pass)
    );

    mi3_div #(.ELEMENT_WIDTH(E), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (div_en),
        .in_valid  (req_valid),
        .in_tag    (req_tag),
        .in_cof    (req_cof),
        .in_det    (req_det),
        .in_pass   (req_pass),
        .out_valid (dv_valid),
        .out_tag   (dv_tag),
        .out_value (dv_value)
    );

    assign div_en = !ov_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (div_en && dv_valid && dv_tag.last)
            ov_reg <= 1'b1;
        else if (out_ch.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (div_en && dv_valid)
        begin
            asm_reg[dv_tag.idx] <= dv_value;
            if (dv_tag.last)
            begin
                for (int i = 0; i < NUM_ELEM - 1; i++)
                    r_reg[i] <= asm_reg[i];
                r_reg[NUM_ELEM-1] <= dv_value;
                sing_reg          <= dv_tag.sing;
            end
        end
    end

    assign out_ch.valid    = ov_reg;
    assign out_ch.r11      = r_reg[0];
    assign out_ch.r12      = r_reg[1];
    assign out_ch.r13      = r_reg[2];
    assign out_ch.r21      = r_reg[3];
    assign out_ch.r22      = r_reg[4];
    assign out_ch.r23      = r_reg[5];
    assign out_ch.r31      = r_reg[6];
    assign out_ch.r32      = r_reg[7];
    assign out_ch.r33      = r_reg[8];
    assign out_ch.singular = sing_reg;

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid && dv_tag.last |-> dv_tag.idx == LAST_IDX)
        else $error("last element beat with wrong index");

    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !div_en && dv_valid |=> dv_valid && $stable(dv_tag) && $stable(dv_value))
        else $error("divider output moved during stall");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        div_en && dv_valid && dv_tag.last |=> out_ch.valid)
        else $error("finished matrix not presented");

endmodule

### tb/matrix3x3_inverse_core_tb.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core testbench
// drives directed, then random gapped matrix beats, predicts each inverse by exact
// adjugate arithmetic and truncating division, and checks every output beat
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EW    = 32;
    localparam int FB    = 16;
    localparam int LIMIT = 3000000;
    localparam logic signed [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic signed [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};

    typedef logic signed [EW-1:0] elem_t;
    typedef elem_t mat_t [9];
    typedef logic signed [255:0] wide_t;

    typedef struct {
        mat_t r;
        logic singular;
    } inverse_t;

    class inverse_scoreboard;
        inverse_t pending[$];
        int errors;

        function elem_t divide_sat(wide_t cof, wide_t det);
            wide_t q;
            q = (cof <<< (2 * FB)) / det;
            if (q > wide_t'(EMAX)) return EMAX;
            if (q < wide_t'(EMIN)) return EMIN;
            return elem_t'(q);
        endfunction

        function void note_matrix(mat_t m);
            wide_t a [9];
            wide_t det;
            wide_t c [9];
            inverse_t e;
            for (int i = 0; i < 9; i++) a[i] = wide_t'(m[i]);
            det = a[0]*a[4]*a[8] + a[3]*a[7]*a[2] + a[6]*a[1]*a[5]
                - a[0]*a[7]*a[5] - a[6]*a[4]*a[2] - a[3]*a[1]*a[8];
            if (det == 0)
            begin
                e.r = m;
                e.singular = 1'b1;
            end
            else
            begin
                c[0] = a[4]*a[8] - a[5]*a[7];
                c[1] = a[2]*a[7] - a[1]*a[8];
                c[2] = a[1]*a[5] - a[2]*a[4];
                c[3] = a[5]*a[6] - a[3]*a[8];
                c[4] = a[0]*a[8] - a[2]*a[6];
                c[5] = a[2]*a[3] - a[0]*a[5];
                c[6] = a[3]*a[7] - a[4]*a[6];
                c[7] = a[1]*a[6] - a[0]*a[7];
                c[8] = a[0]*a[4] - a[1]*a[3];
                for (int i = 0; i < 9; i++) e.r[i] = divide_sat(c[i], det);
                e.singular = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endfunction

        function void check_inverse(inverse_t got);
            inverse_t e;
            if (pending.size() == 0)
            begin
                report("output beat with nothing expected");
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (got.r[i] !== e.r[i])
                    report($sformatf("r%0d%0d got %h exp %h", i/3+1, i%3+1, got.r[i], e.r[i]));
            if (got.singular !== e.singular)
                report($sformatf("singular got %b exp %b", got.singular, e.singular));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    longint cycles = 0;
    inverse_scoreboard sb = new();
    bit stim_done = 1'b0;

    mi3_in_if  #(.ELEMENT_WIDTH(EW)) in_ch ();
    mi3_out_if #(.ELEMENT_WIDTH(EW)) out_ch ();

    matrix3x3_inverse_core #(.ELEMENT_WIDTH(EW), .FRAC_BITS(FB)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic elem_t rand_elem(int kind);
        case (kind)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(131072)) - 65536);
            2: return elem_t'($signed($urandom_range(16)) - 8) <<< FB;
            3: return ($urandom_range(1)) ? EMAX : EMIN;
            default: return elem_t'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    task automatic drive_matrix(mat_t m);
        in_ch.m11 <= m[0]; in_ch.m12 <= m[1]; in_ch.m13 <= m[2];
        in_ch.m21 <= m[3]; in_ch.m22 <= m[4]; in_ch.m23 <= m[5];
        in_ch.m31 <= m[6]; in_ch.m32 <= m[7]; in_ch.m33 <= m[8];
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_matrix(m);
        @(negedge clk);
    endtask

    task automatic send_matrix(mat_t m);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        drive_matrix(m);
    endtask

    function automatic mat_t random_matrix();
        mat_t m;
        int kind;
        int p;
        kind = $urandom_range(4);
        for (int i = 0; i < 9; i++)
            m[i] = ($urandom_range(9) == 0) ? rand_elem($urandom_range(4)) : rand_elem(kind);
        p = $urandom_range(19);
        // occasionally force a singular case: duplicate or scaled row, zero column
        if (p == 0)
            for (int i = 0; i < 3; i++) m[6+i] = m[i];
        else if (p == 1)
            for (int i = 0; i < 3; i++) m[3+i] = -m[i];
        else if (p == 2)
            for (int i = 0; i < 3; i++) m[i*3+1] = '0;
        return m;
    endfunction

    initial
    begin
        in_ch.valid = 1'b0;
        {in_ch.m11, in_ch.m12, in_ch.m13} = '0;
        {in_ch.m21, in_ch.m22, in_ch.m23} = '0;
        {in_ch.m31, in_ch.m32, in_ch.m33} = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        begin
            mat_t m;
            elem_t one;
            one = elem_t'(1) <<< FB;
            m = '{one, 0, 0, 0, one, 0, 0, 0, one};
            drive_matrix(m);
            m = '{2*one, 0, 0, 0, -4*one, 0, 0, 0, one/2};
            drive_matrix(m);
            m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
            drive_matrix(m);
            m = '{EMAX, EMAX, EMAX, EMIN, EMIN, EMIN, 1, 2, 3};
            drive_matrix(m);
            m = '{EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX};
            drive_matrix(m);
            m = '{EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN};
            drive_matrix(m);
            m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
            drive_matrix(m);
            m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
            drive_matrix(m);
            m = '{EMAX, EMIN, 5, EMIN, EMAX, -7, 3, -1, EMAX};
            drive_matrix(m);
            m = '{0, one, 0, one, 0, 0, 0, 0, one};
            drive_matrix(m);
            m = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 9*one};
            drive_matrix(m);
            m = '{-1, -1, -1, -1, -1, -1, -1, -1, -2};
            drive_matrix(m);
            m = '{one, one, 0, 0, one, one, one, 0, one};
            drive_matrix(m);
            m = '{EMIN, EMIN, 0, 0, EMIN, EMIN, EMIN, 0, EMIN};
            drive_matrix(m);
            for (int n = 0; n < 1850; n++)
                send_matrix(random_matrix());
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int g;
            @(negedge clk);
            if ($urandom_range(3) == 0)
            begin
                g = gap_len();
                if (g > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (g) @(negedge clk);
                end
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            inverse_t got;
            got.r = '{out_ch.r11, out_ch.r12, out_ch.r13, out_ch.r21, out_ch.r22,
                      out_ch.r23, out_ch.r31, out_ch.r32, out_ch.r33};
            got.singular = out_ch.singular;
            sb.check_inverse(got);
        end

    initial
    begin
        wait (stim_done && sb.pending.size() == 0);
        repeat (2 * (16 + EW) + 100) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end
endmodule
